// File: design/scs_pkg.sv
// ---------------------------------------------------------------------------
// scs_pkg: shared types and constants for the statement completeness scanner
// Scan state encoding, character codes and the result record.
// ---------------------------------------------------------------------------
package scs_pkg;

	// scanner state
	typedef enum logic [2:0] {
		ST_NORMAL    = 3'd0,
		ST_SLASH     = 3'd1,
		ST_DASH      = 3'd2,
		ST_BLOCK     = 3'd3,
		ST_BLOCKSTAR = 3'd4,
		ST_LINE      = 3'd5,
		ST_STR       = 3'd6,
		ST_STRESC    = 3'd7
	} scan_state_t;

	// character codes
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// one result transaction
	typedef struct packed {
		logic complete;
		logic fin;
	} scs_result_t;

endpackage

// File: design/scs_step.sv
// ---------------------------------------------------------------------------
// scs_step: per-byte scan logic
// Computes next scan state, next completeness flag and the verdict for
// one input byte, given the current state.
// ---------------------------------------------------------------------------
module scs_step (
	input  scs_pkg::scan_state_t state,
	input  logic                 flag,
	input  logic [7:0]           ch,
	output scs_pkg::scan_state_t state_nxt,
	output logic                 flag_nxt,
	output logic                 verdict
);

	// state after a byte seen in normal text
	function automatic scs_pkg::scan_state_t normal_state(input logic [7:0] c);
		scs_pkg::scan_state_t s;
		begin
			case (c)
				scs_pkg::CH_SLASH: s = scs_pkg::ST_SLASH;
				scs_pkg::CH_DASH:  s = scs_pkg::ST_DASH;
				scs_pkg::CH_QUOTE: s = scs_pkg::ST_STR;
				default:           s = scs_pkg::ST_NORMAL;
			endcase
			return s;
		end
	endfunction

	// flag after a byte seen in normal text
	function automatic logic normal_flag(input logic [7:0] c, input logic f);
		logic r;
		begin
			case (c)
				scs_pkg::CH_SEMI: r = 1'b1;
				scs_pkg::CH_SPACE, scs_pkg::CH_CR, scs_pkg::CH_TAB,
				scs_pkg::CH_LF, scs_pkg::CH_FF,
				scs_pkg::CH_SLASH, scs_pkg::CH_DASH, scs_pkg::CH_QUOTE: r = f;
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	// next state
	always_comb begin
		unique case (state)
			scs_pkg::ST_NORMAL: state_nxt = normal_state(ch);
			scs_pkg::ST_SLASH:
				state_nxt = (ch == scs_pkg::CH_STAR) ? scs_pkg::ST_BLOCK : normal_state(ch);
			scs_pkg::ST_DASH:
				state_nxt = (ch == scs_pkg::CH_DASH) ? scs_pkg::ST_LINE : normal_state(ch);
			scs_pkg::ST_BLOCK:
				state_nxt = (ch == scs_pkg::CH_STAR) ? scs_pkg::ST_BLOCKSTAR : scs_pkg::ST_BLOCK;
			scs_pkg::ST_BLOCKSTAR: begin
				if (ch == scs_pkg::CH_SLASH)
					state_nxt = scs_pkg::ST_SLASH;
				else if (ch == scs_pkg::CH_STAR)
					state_nxt = scs_pkg::ST_BLOCKSTAR;
				else
					state_nxt = scs_pkg::ST_BLOCK;
			end
			scs_pkg::ST_LINE:
				state_nxt = (ch == scs_pkg::CH_LF) ? scs_pkg::ST_NORMAL : scs_pkg::ST_LINE;
			scs_pkg::ST_STR: begin
				if (ch == scs_pkg::CH_BSLASH)
					state_nxt = scs_pkg::ST_STRESC;
				else if (ch == scs_pkg::CH_QUOTE)
					state_nxt = scs_pkg::ST_NORMAL;
				else
					state_nxt = scs_pkg::ST_STR;
			end
			scs_pkg::ST_STRESC: state_nxt = scs_pkg::ST_STR;
			default:            state_nxt = scs_pkg::ST_NORMAL;
		endcase
	end

	// flag update and verdict
	always_comb begin
		unique case (state)
			scs_pkg::ST_NORMAL: flag_nxt = normal_flag(ch, flag);
			scs_pkg::ST_SLASH:
				flag_nxt = (ch == scs_pkg::CH_STAR) ? flag : normal_flag(ch, flag);
			scs_pkg::ST_DASH:
				flag_nxt = (ch == scs_pkg::CH_DASH) ? flag : normal_flag(ch, flag);
			scs_pkg::ST_STR:
				flag_nxt = (ch == scs_pkg::CH_QUOTE) ? 1'b0 : flag;
			default: flag_nxt = flag;
		endcase
		case (state_nxt) inside
			scs_pkg::ST_BLOCK, scs_pkg::ST_BLOCKSTAR,
			scs_pkg::ST_STR, scs_pkg::ST_STRESC: verdict = 1'b0;
			default:                             verdict = flag_nxt;
		endcase
	end

endmodule

// File: design/scs_out_buf.sv
// ---------------------------------------------------------------------------
// scs_out_buf: result register
// Holds one result transaction until the consumer takes it; reports when
// a new result can be loaded in the same cycle.
// ---------------------------------------------------------------------------
module scs_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  scs_pkg::scs_result_t load_data,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output scs_pkg::scs_result_t out_data
);

	logic                 valid_q;
	scs_pkg::scs_result_t data_q;

	// free when empty or being drained this cycle
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			data_q <= load_data;
	end

endmodule

// File: design/statement_complete_scanner.sv
// ---------------------------------------------------------------------------
// statement_complete_scanner: statement completeness scanner
// Scans statement text one byte per transaction and reports whether the
// text so far ends in a semicolon followed only by whitespace or comments.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  input   | in_valid, in_ready   | text_byte[7:0], final_byte
//  output  | out_valid, out_ready | complete_so_far, final_out
//
// One byte per cycle unless stalled; its result appears in the output
// register in the cycle after acceptance. The scan state update is a
// single combinational step. Reset empties the output register and sets
// the scanner to normal text with the complete flag set. A stalled output
// blocks input only while the output register is full and not being drained.
module statement_complete_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       complete_so_far,
	output logic       final_out
);

	scs_pkg::scan_state_t state_q;
	scs_pkg::scan_state_t state_nxt;
	logic                 flag_q;
	logic                 flag_nxt;
	logic                 verdict;
	logic                 in_accept;
	logic                 can_load;
	scs_pkg::scs_result_t res;
	scs_pkg::scs_result_t res_out;

	assign in_ready  = can_load;
	assign in_accept = in_valid && can_load;

	// per-byte scan logic
	scs_step u_step (
		.state     (state_q),
		.flag      (flag_q),
		.ch        (text_byte),
		.state_nxt (state_nxt),
		.flag_nxt  (flag_nxt),
		.verdict   (verdict)
	);

	// scanner state, back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scs_pkg::ST_NORMAL;
			flag_q  <= 1'b1;
		end else if (in_accept) begin
			if (final_byte) begin
				state_q <= scs_pkg::ST_NORMAL;
				flag_q  <= 1'b1;
			end else begin
				state_q <= state_nxt;
				flag_q  <= flag_nxt;
			end
		end
	end

	assign res.complete = verdict;
	assign res.fin      = final_byte;

	// result register
	scs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign complete_so_far = res_out.complete;
	assign final_out       = res_out.fin;

	// last byte returns the scanner to its reset state
	a_final_reset: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && final_byte |=> state_q == scs_pkg::ST_NORMAL && flag_q)
		else $error("scanner not reset after last byte");

	// every accepted byte yields a pending result
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid && final_out == $past(final_byte))
		else $error("result missing after accepted byte");

	// open comment or string never reports complete
	a_open_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !final_byte |=>
			!(state_q == scs_pkg::ST_BLOCK || state_q == scs_pkg::ST_BLOCKSTAR ||
			  state_q == scs_pkg::ST_STR || state_q == scs_pkg::ST_STRESC) ||
			!complete_so_far)
		else $error("complete reported inside comment or string");

	// full, stalled result register blocks input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result register full");

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the statement completeness scanner
// Feeds statement text byte by byte through the input channel and checks
// every verdict against a typed table value or a cycle-free bench model.
// A short stimulus table covers the corner cases, then randomly composed
// statements (words, comments, strings, stray slashes and dashes, noise)
// run with bursty input, a stalling output and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int TOTAL_BYTES  = 1150;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int N_DIRECTED   = 25;

	localparam logic [7:0] CH_MIN    = 8'h01;
	localparam logic [7:0] CH_MAX    = 8'hFF;
	localparam logic [7:0] CH_LETTER = 8'h78;

	// one row of the directed table
	typedef struct packed {
		logic [7:0] c;
		logic       fin;
		logic       typed;
		logic       want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_ready;
	logic       complete_so_far;
	logic       final_out;

	// scanner model state
	scs_pkg::scan_state_t scan_st;
	logic                 terminated;

	scs_pkg::scs_result_t verdict_q[$];
	logic [7:0]           text_q[$];
	dir_row_t             dir_rows [0:N_DIRECTED-1];

	int  burst_left;
	int  quiet_cycles;
	int  errors;
	int  bytes_sent;
	int  stmts_sent;
	int  verdicts_checked;
	int  verdicts_complete;
	bit  hold_req;

	statement_complete_scanner i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.text_byte       (text_byte),
		.final_byte      (final_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.complete_so_far (complete_so_far),
		.final_out       (final_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model: back to normal text, empty text counts as complete
	function automatic void reset_scanner();
		scan_st    = scs_pkg::ST_NORMAL;
		terminated = 1'b1;
	endfunction

	// model: a character seen in normal text
	function automatic void plain_char(input logic [7:0] c);
		case (c)
			scs_pkg::CH_SEMI: terminated = 1'b1;
			scs_pkg::CH_SPACE, scs_pkg::CH_CR, scs_pkg::CH_TAB,
			scs_pkg::CH_LF, scs_pkg::CH_FF: ;
			scs_pkg::CH_SLASH: scan_st = scs_pkg::ST_SLASH;
			scs_pkg::CH_DASH: scan_st = scs_pkg::ST_DASH;
			scs_pkg::CH_QUOTE: scan_st = scs_pkg::ST_STR;
			default: terminated = 1'b0;
		endcase
	endfunction

	// model: advance by one byte and return the verdict for the text so far
	function automatic logic scan_byte(input logic [7:0] c, input logic fin);
		logic v;
		case (scan_st)
			scs_pkg::ST_NORMAL: plain_char(c);
			scs_pkg::ST_SLASH: begin
				scan_st = scs_pkg::ST_NORMAL;
				if (c == scs_pkg::CH_STAR)
					scan_st = scs_pkg::ST_BLOCK;
				else
					plain_char(c);
			end
			scs_pkg::ST_DASH: begin
				scan_st = scs_pkg::ST_NORMAL;
				if (c == scs_pkg::CH_DASH)
					scan_st = scs_pkg::ST_LINE;
				else
					plain_char(c);
			end
			scs_pkg::ST_BLOCK: if (c == scs_pkg::CH_STAR) scan_st = scs_pkg::ST_BLOCKSTAR;
			scs_pkg::ST_BLOCKSTAR: begin
				// the closing slash comes back as a pending slash
				if (c == scs_pkg::CH_SLASH)
					scan_st = scs_pkg::ST_SLASH;
				else if (c != scs_pkg::CH_STAR)
					scan_st = scs_pkg::ST_BLOCK;
			end
			scs_pkg::ST_LINE: if (c == scs_pkg::CH_LF) scan_st = scs_pkg::ST_NORMAL;
			scs_pkg::ST_STR: begin
				if (c == scs_pkg::CH_BSLASH) begin
					scan_st = scs_pkg::ST_STRESC;
				end else if (c == scs_pkg::CH_QUOTE) begin
					scan_st    = scs_pkg::ST_NORMAL;
					terminated = 1'b0;
				end
			end
			default: scan_st = scs_pkg::ST_STR;
		endcase
		v = (scan_st inside {scs_pkg::ST_BLOCK, scs_pkg::ST_BLOCKSTAR,
			scs_pkg::ST_STR, scs_pkg::ST_STRESC}) ? 1'b0 : terminated;
		if (fin)
			reset_scanner();
		return v;
	endfunction

	function automatic logic [7:0] space_char();
		case ($urandom_range(0, 4))
			0: return scs_pkg::CH_SPACE;
			1: return scs_pkg::CH_TAB;
			2: return scs_pkg::CH_CR;
			3: return scs_pkg::CH_LF;
			default: return scs_pkg::CH_FF;
		endcase
	endfunction

	// offer one byte, in bursts with random gaps, and log its verdict once taken
	task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
			input logic want);
		scs_pkg::scs_result_t exp;
		logic                 v;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6)) @(posedge clk);
			burst_left = $urandom_range(1, 64);
		end
		burst_left--;
		in_valid   <= 1'b1;
		text_byte  <= c;
		final_byte <= fin;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		v            = scan_byte(c, fin);
		exp.complete = typed ? want : v;
		exp.fin      = fin;
		verdict_q.push_back(exp);
		bytes_sent++;
	endtask

	// hold the input until every verdict in flight has come back
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		do @(posedge clk); while (verdict_q.size() != 0);
	endtask

	// build one statement from random tokens, sometimes cut short
	task automatic compose_statement();
		int         n_tok;
		int         len;
		int         t;
		int         k;
		logic [7:0] ch;
		text_q.delete();
		n_tok = $urandom_range(1, 8);
		for (t = 0; t < n_tok; t++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					len = $urandom_range(1, 6);
					repeat (len) text_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
				end
				2: begin
					len = $urandom_range(1, 3);
					repeat (len) text_q.push_back(space_char());
				end
				3: text_q.push_back(scs_pkg::CH_SEMI);
				4: begin
					// block comment, body may hold stray stars and slashes
					text_q.push_back(scs_pkg::CH_SLASH);
					text_q.push_back(scs_pkg::CH_STAR);
					len = $urandom_range(0, 5);
					repeat (len) begin
						k = $urandom_range(0, 3);
						ch = (k == 0) ? scs_pkg::CH_STAR : (k == 1) ? scs_pkg::CH_SLASH :
							8'($urandom_range(1, 255));
						text_q.push_back(ch);
					end
					text_q.push_back(scs_pkg::CH_STAR);
					text_q.push_back(scs_pkg::CH_SLASH);
				end
				5: begin
					// line comment closed by a newline
					text_q.push_back(scs_pkg::CH_DASH);
					text_q.push_back(scs_pkg::CH_DASH);
					len = $urandom_range(0, 5);
					repeat (len) begin
						ch = 8'($urandom_range(1, 255));
						text_q.push_back((ch == scs_pkg::CH_LF) ? scs_pkg::CH_SPACE : ch);
					end
					text_q.push_back(scs_pkg::CH_LF);
				end
				6: begin
					// quoted string with escapes
					text_q.push_back(scs_pkg::CH_QUOTE);
					len = $urandom_range(0, 5);
					repeat (len) begin
						if ($urandom_range(0, 3) == 0) begin
							text_q.push_back(scs_pkg::CH_BSLASH);
							text_q.push_back(8'($urandom_range(1, 255)));
						end else begin
							ch = 8'($urandom_range(1, 255));
							text_q.push_back((ch == scs_pkg::CH_QUOTE ||
								ch == scs_pkg::CH_BSLASH) ? CH_LETTER : ch);
						end
					end
					text_q.push_back(scs_pkg::CH_QUOTE);
				end
				7: text_q.push_back($urandom_range(0, 1) ? scs_pkg::CH_SLASH : scs_pkg::CH_DASH);
				8: begin
					len = $urandom_range(1, 4);
					repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
				end
				default: begin
					text_q.push_back(scs_pkg::CH_SEMI);
					text_q.push_back(space_char());
				end
			endcase
		end
		if ($urandom_range(0, 9) < 7)
			text_q.push_back(scs_pkg::CH_SEMI);
		if ($urandom_range(0, 2) == 0)
			text_q.push_back(space_char());
		// broken statement: drop the tail
		if ($urandom_range(0, 7) == 0 && text_q.size() > 1) begin
			k = $urandom_range(1, text_q.size() - 1);
			while (text_q.size() > k) void'(text_q.pop_back());
		end
	endtask

	// output side: own stall pattern plus one long hold-off on request
	initial begin
		int   mode;
		int   len;
		int   n;
		logic rdy;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len  = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 40);
				for (n = 0; n < len; n++) begin
					case (mode)
						0: rdy = 1'b1;
						1: rdy = 1'b0;
						2: rdy = 1'($urandom_range(0, 1));
						default: rdy = (n % 3) != 0;
					endcase
					out_ready <= rdy;
					@(posedge clk);
				end
			end
		end
	end

	// verdict check and watchdog, sampled mid-cycle where everything is settled
	always @(negedge clk) begin
		scs_pkg::scs_result_t exp;
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict transaction with none expected: complete_so_far=%0b final_out=%0b",
					complete_so_far, final_out);
				errors++;
			end else begin
				exp = verdict_q.pop_front();
				if (complete_so_far !== exp.complete) begin
					$error("complete_so_far: expected %0b, got %0b", exp.complete, complete_so_far);
					errors++;
				end
				if (final_out !== exp.fin) begin
					$error("final_out: expected %0b, got %0b", exp.fin, final_out);
					errors++;
				end
				verdicts_checked++;
				if (exp.complete)
					verdicts_complete++;
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, %0d verdicts outstanding",
				quiet_cycles, verdict_q.size());
			$display("statement_complete_scanner: mismatch");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		text_byte  = 8'h00;
		final_byte = 1'b0;
		hold_req   = 1'b0;
		reset_scanner();

		// corner cases: field extremes, lone slash and dash, nested comment
		// closing, line comment and escaped quote
		dir_rows = '{
			'{CH_MIN,             1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_SEMI,   1'b1, 1'b1, 1'b1},
			'{CH_MAX,             1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_SEMI,   1'b0, 1'b1, 1'b1},
			'{scs_pkg::CH_SPACE,  1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0},
			'{CH_LETTER,          1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_SEMI,   1'b0, 1'b1, 1'b1},
			'{scs_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_STAR,   1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_STAR,   1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_STAR,   1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_STAR,   1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_DASH,   1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_DASH,   1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_LF,     1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_QUOTE,  1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_BSLASH, 1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_QUOTE,  1'b0, 1'b1, 1'b0},
			'{scs_pkg::CH_QUOTE,  1'b0, 1'b0, 1'b0},
			'{scs_pkg::CH_SEMI,   1'b0, 1'b1, 1'b1},
			'{scs_pkg::CH_DASH,   1'b0, 1'b0, 1'b0},
			'{CH_LETTER,          1'b1, 1'b0, 1'b0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIRECTED; i++) begin
			send_byte(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
			if (dir_rows[i].fin)
				stmts_sent++;
		end
		wait_for_verdicts();

		// random statements, opened by a long output hold-off
		hold_req = 1'b1;
		while (bytes_sent < TOTAL_BYTES) begin
			compose_statement();
			foreach (text_q[j])
				send_byte(text_q[j], j == text_q.size() - 1, 1'b0, 1'b0);
			stmts_sent++;
			if ($urandom_range(0, 15) == 0)
				wait_for_verdicts();
		end
		in_valid <= 1'b0;

		while (verdict_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);

		$display("scanned %0d bytes in %0d statements, %0d verdicts checked",
			bytes_sent, stmts_sent, verdicts_checked);
		$display("%0d verdicts complete, %0d open, %0d errors",
			verdicts_complete, verdicts_checked - verdicts_complete, errors);
		if (errors == 0)
			$display("statement_complete_scanner: match");
		else
			$display("statement_complete_scanner: mismatch");
		$finish;
	end

endmodule
